[rtl/bencode_token_stream_parser_unit_macros.svh]
// Assertion macros for the parser RTL.
`ifndef BENCODE_TOKEN_STREAM_PARSER_UNIT_MACROS_SVH
`define BENCODE_TOKEN_STREAM_PARSER_UNIT_MACROS_SVH

// Check that a condition implies a consequence in the same cycle.
`define BTSP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that a condition implies a consequence in the following cycle.
`define BTSP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/btsp_pkg.sv]
// Package: token codes, error codes, character constants and shared types.
`default_nettype none

package btsp_pkg;

	localparam int STACK_DEPTH_DEF  = 16;
	localparam int ID_WIDTH_DEF     = 32;
	localparam int LENGTH_WIDTH_DEF = 32;

	localparam int CID_W  = 32;
	localparam int INT_W  = 64;

	// token kinds
	localparam logic [2:0] KIND_INT    = 3'd0;
	localparam logic [2:0] KIND_LBEGIN = 3'd1;
	localparam logic [2:0] KIND_DBEGIN = 3'd2;
	localparam logic [2:0] KIND_LEND   = 3'd3;
	localparam logic [2:0] KIND_DEND   = 3'd4;
	localparam logic [2:0] KIND_SBYTE  = 3'd5;
	localparam logic [2:0] KIND_EMPTY  = 3'd6;
	localparam logic [2:0] KIND_ERROR  = 3'd7;

	// error codes
	localparam logic [2:0] ERR_NONE        = 3'd0;
	localparam logic [2:0] ERR_EMPTY_STACK = 3'd1;
	localparam logic [2:0] ERR_STACK_FULL  = 3'd2;
	localparam logic [2:0] ERR_BAD_DIGIT   = 3'd3;
	localparam logic [2:0] ERR_INT_OVF     = 3'd4;
	localparam logic [2:0] ERR_TOO_LONG    = 3'd5;

	// stream characters
	localparam logic [7:0] CH_I     = 8'h69;
	localparam logic [7:0] CH_L     = 8'h6C;
	localparam logic [7:0] CH_D     = 8'h64;
	localparam logic [7:0] CH_E     = 8'h65;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// token as decided by the parser; pop marks an end token whose id and
	// kind come from the stack read
	typedef struct packed {
		logic [2:0]       kind;
		logic [INT_W-1:0] ival;
		logic [CID_W-1:0] cid;
		logic [7:0]       sbyte;
		logic             first;
		logic             last;
		logic [2:0]       err;
		logic             pop;
	} tok_t;

	// stack access request
	typedef struct packed {
		logic push;
		logic pop;
	} stack_req_t;

endpackage

`default_nettype wire

[rtl/btsp_byte_if.sv]
// Channel interfaces: input byte stream and output token stream.
`default_nettype none

interface btsp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

interface btsp_token_if;
	logic        valid;
	logic        ready;
	logic [2:0]  token_kind;
	logic [63:0] int_value;
	logic [31:0] container_id;
	logic [7:0]  string_data;
	logic        first_of_string;
	logic        last_of_string;
	logic [2:0]  error_code;

	modport source (output valid, output token_kind, output int_value, output container_id,
		output string_data, output first_of_string, output last_of_string,
		output error_code, input ready);
	modport sink (input valid, input token_kind, input int_value, input container_id,
		input string_data, input first_of_string, input last_of_string,
		input error_code, output ready);
endinterface

`default_nettype wire

[rtl/btsp_stack_mem.sv]
// Container stack memory: one write port, one read port with registered data.
`default_nettype none

module btsp_stack_mem #(
	parameter int DEPTH = btsp_pkg::STACK_DEPTH_DEF,
	parameter int WIDTH = btsp_pkg::ID_WIDTH_DEF + 1,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write on push
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read on pop, hold data until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

[rtl/btsp_parse.sv]
// Byte parser: phase, number accumulation, string count and stack pointer.
`default_nettype none
`include "bencode_token_stream_parser_unit_macros.svh"

module btsp_parse #(
	parameter int STACK_DEPTH  = btsp_pkg::STACK_DEPTH_DEF,
	parameter int ID_WIDTH     = btsp_pkg::ID_WIDTH_DEF,
	parameter int LENGTH_WIDTH = btsp_pkg::LENGTH_WIDTH_DEF,
	parameter int AW           = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                accept,
	input  wire logic [7:0]          data_byte,
	output logic                     tok_valid,
	output btsp_pkg::tok_t           tok,
	output btsp_pkg::stack_req_t     req,
	output logic [AW-1:0]            waddr,
	output logic [AW-1:0]            raddr,
	output logic [ID_WIDTH:0]        wdata
);

	localparam int LVL_W = $clog2(STACK_DEPTH + 1);
	localparam int MAC_W = btsp_pkg::INT_W + 4;

	typedef enum logic [2:0] {
		PH_EXPECT,
		PH_INT_START,
		PH_INT_MINUS,
		PH_INT_DIGITS,
		PH_LENGTH,
		PH_STRING
	} phase_t;

	phase_t                     phase_q, phase_n;
	logic [btsp_pkg::INT_W-1:0] acc_q, acc_n;
	logic                       minus_q, minus_n;
	logic [LENGTH_WIDTH-1:0]    rem_q, rem_n;
	logic                       first_q, first_n;
	logic [LVL_W-1:0]           level_q, level_n;
	logic [ID_WIDTH-1:0]        nid_q, nid_n;

	logic             is_digit;
	logic [3:0]       digit;
	logic [MAC_W-1:0] mac;
	logic             int_ovf;
	logic             len_ovf;
	logic             stack_full;
	logic             stack_empty;
	logic             last_byte;

	// decode the byte and form the next decimal value (times ten as 8x + 2x)
	assign is_digit    = (data_byte >= btsp_pkg::CH_ZERO) && (data_byte <= btsp_pkg::CH_NINE);
	assign digit       = data_byte[3:0];
	assign mac         = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + MAC_W'(digit);
	assign int_ovf     = |mac[MAC_W-1:btsp_pkg::INT_W];
	assign len_ovf     = |mac[MAC_W-1:LENGTH_WIDTH];
	assign stack_full  = (level_q == LVL_W'(STACK_DEPTH));
	assign stack_empty = (level_q == '0);
	assign last_byte   = (rem_q <= LENGTH_WIDTH'(1));

	// stack addresses and write data
	assign waddr = level_q[AW-1:0];
	assign raddr = AW'(level_q - LVL_W'(1));
	assign wdata = {(data_byte == btsp_pkg::CH_D), nid_q};

	// next state and token for the byte
	always_comb begin
		phase_n   = phase_q;
		acc_n     = acc_q;
		minus_n   = minus_q;
		rem_n     = rem_q;
		first_n   = first_q;
		level_n   = level_q;
		nid_n     = nid_q;
		tok_valid = 1'b0;
		tok       = '0;
		req       = '0;

		case (phase_q)
			PH_STRING: begin
				tok_valid = 1'b1;
				tok.kind  = btsp_pkg::KIND_SBYTE;
				tok.sbyte = data_byte;
				tok.first = first_q;
				tok.last  = last_byte;
				first_n   = 1'b0;
				rem_n     = last_byte ? '0 : rem_q - LENGTH_WIDTH'(1);
				if (last_byte) begin
					phase_n = PH_EXPECT;
				end
			end
			PH_INT_START, PH_INT_MINUS, PH_INT_DIGITS: begin
				if (data_byte == btsp_pkg::CH_MINUS && phase_q == PH_INT_START) begin
					minus_n = 1'b1;
					phase_n = PH_INT_MINUS;
				end else if (data_byte == btsp_pkg::CH_E) begin
					tok_valid = 1'b1;
					phase_n   = PH_EXPECT;
					acc_n     = '0;
					minus_n   = 1'b0;
					if (phase_q != PH_INT_DIGITS) begin
						tok.kind = btsp_pkg::KIND_ERROR;
						tok.err  = btsp_pkg::ERR_BAD_DIGIT;
					end else begin
						tok.kind = btsp_pkg::KIND_INT;
						tok.ival = minus_q ? '0 - acc_q : acc_q;
					end
				end else if (!is_digit || int_ovf) begin
					tok_valid = 1'b1;
					tok.kind  = btsp_pkg::KIND_ERROR;
					tok.err   = is_digit ? btsp_pkg::ERR_INT_OVF : btsp_pkg::ERR_BAD_DIGIT;
					phase_n   = PH_EXPECT;
					acc_n     = '0;
					minus_n   = 1'b0;
				end else begin
					acc_n   = mac[btsp_pkg::INT_W-1:0];
					phase_n = PH_INT_DIGITS;
				end
			end
			PH_LENGTH: begin
				if (data_byte == btsp_pkg::CH_COLON) begin
					acc_n = '0;
					if (acc_q == '0) begin
						tok_valid = 1'b1;
						tok.kind  = btsp_pkg::KIND_EMPTY;
						phase_n   = PH_EXPECT;
					end else begin
						rem_n   = acc_q[LENGTH_WIDTH-1:0];
						first_n = 1'b1;
						phase_n = PH_STRING;
					end
				end else if (!is_digit || len_ovf) begin
					tok_valid = 1'b1;
					tok.kind  = btsp_pkg::KIND_ERROR;
					tok.err   = is_digit ? btsp_pkg::ERR_TOO_LONG : btsp_pkg::ERR_BAD_DIGIT;
					phase_n   = PH_EXPECT;
					acc_n     = '0;
					minus_n   = 1'b0;
				end else begin
					acc_n = mac[btsp_pkg::INT_W-1:0];
				end
			end
			default: begin
				phase_n = PH_EXPECT;
				if (data_byte == btsp_pkg::CH_I) begin
					acc_n   = '0;
					minus_n = 1'b0;
					phase_n = PH_INT_START;
				end else if (data_byte == btsp_pkg::CH_L || data_byte == btsp_pkg::CH_D) begin
					tok_valid = 1'b1;
					if (stack_full) begin
						tok.kind = btsp_pkg::KIND_ERROR;
						tok.err  = btsp_pkg::ERR_STACK_FULL;
						acc_n    = '0;
						minus_n  = 1'b0;
					end else begin
						tok.kind = (data_byte == btsp_pkg::CH_D) ? btsp_pkg::KIND_DBEGIN
							: btsp_pkg::KIND_LBEGIN;
						tok.cid  = btsp_pkg::CID_W'(nid_q);
						req.push = 1'b1;
						level_n  = level_q + LVL_W'(1);
						nid_n    = nid_q + ID_WIDTH'(1);
					end
				end else if (data_byte == btsp_pkg::CH_E) begin
					tok_valid = 1'b1;
					if (stack_empty) begin
						tok.kind = btsp_pkg::KIND_ERROR;
						tok.err  = btsp_pkg::ERR_EMPTY_STACK;
						acc_n    = '0;
						minus_n  = 1'b0;
					end else begin
						tok.pop = 1'b1;
						req.pop = 1'b1;
						level_n = level_q - LVL_W'(1);
					end
				end else if (is_digit) begin
					acc_n   = btsp_pkg::INT_W'(digit);
					phase_n = PH_LENGTH;
				end else begin
					tok_valid = 1'b1;
					tok.kind  = btsp_pkg::KIND_ERROR;
					tok.err   = btsp_pkg::ERR_BAD_DIGIT;
					acc_n     = '0;
					minus_n   = 1'b0;
				end
			end
		endcase
	end

	// advance state on each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_EXPECT;
			acc_q   <= '0;
			minus_q <= 1'b0;
			rem_q   <= '0;
			first_q <= 1'b0;
			level_q <= '0;
			nid_q   <= '0;
		end else if (accept) begin
			phase_q <= phase_n;
			acc_q   <= acc_n;
			minus_q <= minus_n;
			rem_q   <= rem_n;
			first_q <= first_n;
			level_q <= level_n;
			nid_q   <= nid_n;
		end
	end

	`BTSP_ASSERT_SAME(a_level_bound, clk, arst_n, 1'b1, level_q <= LVL_W'(STACK_DEPTH), "stack level beyond depth")
	`BTSP_ASSERT_SAME(a_push_room, clk, arst_n, req.push, !stack_full, "push into a full stack")
	`BTSP_ASSERT_SAME(a_pop_data, clk, arst_n, req.pop, !stack_empty, "pop from an empty stack")
	`BTSP_ASSERT_NEXT(a_push_step, clk, arst_n, accept && req.push, level_q == $past(level_q) + LVL_W'(1), "push did not raise level")
	`BTSP_ASSERT_SAME(a_string_count, clk, arst_n, phase_q == PH_STRING, rem_q != '0, "string phase with zero count")

endmodule

`default_nettype wire

[rtl/bencode_token_stream_parser_unit.sv]
// Top level: byte parser, container stack memory and output token register.
//
//  channel   | dir | handshake     | payload
//  ----------+-----+---------------+-----------------------------------------------
//  byte_ch   | in  | valid / ready | data_byte
//  token_ch  | out | valid / ready | token_kind, int_value, container_id,
//            |     |               | string_data, first/last_of_string, error_code
//
// One byte is taken per cycle unless a stalled token holds the output; its token,
// if any, is shown the next cycle. An end token reads the stack memory at the
// transfer edge; the registered read data forms the token id and kind as it is shown.
// Reset clears the parser state and the output valid; the stack memory is not cleared.
// A stalled token holds its register; a new byte is taken when the register is
// empty or is being drained in the same cycle.
`default_nettype none

module bencode_token_stream_parser_unit #(
	parameter int STACK_DEPTH  = btsp_pkg::STACK_DEPTH_DEF,
	parameter int ID_WIDTH     = btsp_pkg::ID_WIDTH_DEF,
	parameter int LENGTH_WIDTH = btsp_pkg::LENGTH_WIDTH_DEF
) (
	input wire logic    clk,
	input wire logic    arst_n,
	btsp_byte_if.sink   byte_ch,
	btsp_token_if.source token_ch
);

	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

	logic                 accept;
	logic                 tok_valid;
	btsp_pkg::tok_t       tok;
	btsp_pkg::stack_req_t req;
	logic [AW-1:0]        waddr;
	logic [AW-1:0]        raddr;
	logic [ID_WIDTH:0]    wdata;
	logic [ID_WIDTH:0]    rdata;

	logic           valid_s1;
	btsp_pkg::tok_t tok_s1;

	assign byte_ch.ready = !valid_s1 || token_ch.ready;
	assign accept        = byte_ch.valid && byte_ch.ready;

	btsp_parse #(
		.STACK_DEPTH  (STACK_DEPTH),
		.ID_WIDTH     (ID_WIDTH),
		.LENGTH_WIDTH (LENGTH_WIDTH),
		.AW           (AW)
	) u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.data_byte (byte_ch.data_byte),
		.tok_valid (tok_valid),
		.tok       (tok),
		.req       (req),
		.waddr     (waddr),
		.raddr     (raddr),
		.wdata     (wdata)
	);

	btsp_stack_mem #(
		.DEPTH (STACK_DEPTH),
		.WIDTH (ID_WIDTH + 1),
		.AW    (AW)
	) u_stack (
		.clk   (clk),
		.we    (accept && req.push),
		.waddr (waddr),
		.wdata (wdata),
		.re    (accept && req.pop),
		.raddr (raddr),
		.rdata (rdata)
	);

	// hold the token until its transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= tok_valid;
		end else if (token_ch.ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tok_s1 <= tok;
		end
	end

	// fill end tokens from the stack read
	assign token_ch.valid           = valid_s1;
	assign token_ch.token_kind      = tok_s1.pop
		? (rdata[ID_WIDTH] ? btsp_pkg::KIND_DEND : btsp_pkg::KIND_LEND) : tok_s1.kind;
	assign token_ch.int_value       = tok_s1.ival;
	assign token_ch.container_id    = tok_s1.pop
		? btsp_pkg::CID_W'(rdata[ID_WIDTH-1:0]) : tok_s1.cid;
	assign token_ch.string_data     = tok_s1.sbyte;
	assign token_ch.first_of_string = tok_s1.first;
	assign token_ch.last_of_string  = tok_s1.last;
	assign token_ch.error_code      = tok_s1.err;

endmodule

`default_nettype wire

[tb/bencode_token_stream_parser_unit_tb.sv]
// Testbench for the bencode token stream parser: byte stimulus, token prediction and checking.
`default_nettype none

module bencode_token_stream_parser_unit_tb;
	import btsp_pkg::*;

	localparam int          IDLE_PCT   = 6;
	localparam int          MAX_PRINTS = 50;
	localparam logic [63:0] LEN_MAX    = 64'h0000_0000_FFFF_FFFF;
	localparam logic [63:0] INT_MAX    = 64'hFFFF_FFFF_FFFF_FFFF;

	typedef enum logic [2:0] {
		AWAIT_TOKEN, INT_OPEN, INT_SIGN, INT_BODY, LEN_BODY, STR_BODY
	} parse_phase_e;

	typedef struct packed {
		logic [2:0]  kind;
		logic [63:0] ival;
		logic [31:0] cid;
		logic [7:0]  sdata;
		logic        first;
		logic        last;
		logic [2:0]  err;
	} bencode_token_t;

	logic clk;
	logic arst_n;
	logic steady;

	btsp_byte_if  byte_ch ();
	btsp_token_if token_ch ();

	bencode_token_stream_parser_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.byte_ch  (byte_ch),
		.token_ch (token_ch)
	);

	// stream bytes still to send and tokens still owed by the block
	logic [7:0]     byte_backlog[$];
	bencode_token_t pending_tokens[$];

	int bytes_accepted;
	int tokens_checked;
	int mismatch_count;
	int kind_tally[8];
	int err_tally[8];
	bit byte_taken;

	// parser state mirror
	parse_phase_e parse_phase = AWAIT_TOKEN;
	logic [63:0]  num_acc     = '0;
	logic         num_neg     = 1'b0;
	logic [63:0]  str_left    = '0;
	logic         str_first   = 1'b0;
	logic [31:0]  nest_ids[STACK_DEPTH_DEF];
	logic         nest_dict[STACK_DEPTH_DEF];
	int           nest_level  = 0;
	logic [31:0]  next_id     = '0;

	// no idling on either side for a stretch in the middle of the run
	assign steady = (bytes_accepted >= 500 && bytes_accepted < 800);

	// clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic bit is_digit(input logic [7:0] b);
		return b >= CH_ZERO && b <= CH_NINE;
	endfunction

	// drop back to expecting a token and build the error token
	function automatic bencode_token_t raise_error(input logic [2:0] code);
		bencode_token_t t;
		t           = '0;
		t.kind      = KIND_ERROR;
		t.err       = code;
		parse_phase = AWAIT_TOKEN;
		num_acc     = '0;
		num_neg     = 1'b0;
		return t;
	endfunction

	// append one byte to the stimulus backlog
	function automatic void queue_byte(input logic [7:0] b);
		byte_backlog.insert(byte_backlog.size(), b);
	endfunction

	// advance the parser mirror by one byte and queue the token it yields
	task automatic tokenize_byte(input logic [7:0] b);
		bencode_token_t t;
		bit             emit;
		logic [63:0]    d;
		t    = '0;
		emit = 1'b0;
		d    = {56'd0, b - CH_ZERO};
		case (parse_phase)
			STR_BODY: begin
				t.kind    = KIND_SBYTE;
				t.sdata   = b;
				t.first   = str_first;
				t.last    = (str_left <= 1);
				str_first = 1'b0;
				if (t.last) begin
					str_left    = '0;
					parse_phase = AWAIT_TOKEN;
				end else begin
					str_left = str_left - 64'd1;
				end
				emit = 1'b1;
			end
			INT_OPEN, INT_SIGN, INT_BODY: begin
				if (b == CH_MINUS && parse_phase == INT_OPEN) begin
					num_neg     = 1'b1;
					parse_phase = INT_SIGN;
				end else if (b == CH_E) begin
					if (parse_phase != INT_BODY) begin
						t = raise_error(ERR_BAD_DIGIT);
					end else begin
						t.kind      = KIND_INT;
						t.ival      = num_neg ? (64'd0 - num_acc) : num_acc;
						parse_phase = AWAIT_TOKEN;
						num_acc     = '0;
						num_neg     = 1'b0;
					end
					emit = 1'b1;
				end else if (!is_digit(b)) begin
					t    = raise_error(ERR_BAD_DIGIT);
					emit = 1'b1;
				end else if (num_acc > (INT_MAX - d) / 64'd10) begin
					t    = raise_error(ERR_INT_OVF);
					emit = 1'b1;
				end else begin
					num_acc     = num_acc * 64'd10 + d;
					parse_phase = INT_BODY;
				end
			end
			LEN_BODY: begin
				if (b == CH_COLON) begin
					if (num_acc == 0) begin
						t.kind      = KIND_EMPTY;
						parse_phase = AWAIT_TOKEN;
						emit        = 1'b1;
					end else begin
						str_left    = num_acc;
						str_first   = 1'b1;
						parse_phase = STR_BODY;
					end
					num_acc = '0;
				end else if (!is_digit(b)) begin
					t    = raise_error(ERR_BAD_DIGIT);
					emit = 1'b1;
				end else if (num_acc > (LEN_MAX - d) / 64'd10) begin
					t    = raise_error(ERR_TOO_LONG);
					emit = 1'b1;
				end else begin
					num_acc = num_acc * 64'd10 + d;
				end
			end
			default: begin
				emit = 1'b1;
				if (b == CH_I) begin
					num_acc     = '0;
					num_neg     = 1'b0;
					parse_phase = INT_OPEN;
					emit        = 1'b0;
				end else if (b == CH_L || b == CH_D) begin
					if (nest_level >= STACK_DEPTH_DEF) begin
						t = raise_error(ERR_STACK_FULL);
					end else begin
						nest_ids[nest_level]  = next_id;
						nest_dict[nest_level] = (b == CH_D);
						nest_level++;
						t.kind  = (b == CH_D) ? KIND_DBEGIN : KIND_LBEGIN;
						t.cid   = next_id;
						next_id = next_id + 32'd1;
					end
				end else if (b == CH_E) begin
					if (nest_level == 0) begin
						t = raise_error(ERR_EMPTY_STACK);
					end else begin
						nest_level--;
						t.kind = nest_dict[nest_level] ? KIND_DEND : KIND_LEND;
						t.cid  = nest_ids[nest_level];
					end
				end else if (is_digit(b)) begin
					num_acc     = d;
					parse_phase = LEN_BODY;
					emit        = 1'b0;
				end else begin
					t = raise_error(ERR_BAD_DIGIT);
				end
			end
		endcase
		if (emit) begin
			pending_tokens.insert(pending_tokens.size(), t);
			kind_tally[t.kind]++;
			err_tally[t.err]++;
		end
	endtask

	task automatic log_mismatch(input string what);
		if (mismatch_count < MAX_PRINTS)
			$display("MISMATCH @%0t: %s", $realtime, what);
		mismatch_count++;
	endtask

	task automatic compare_field(input string name, input logic [63:0] got,
		input logic [63:0] want);
		if (got !== want)
			log_mismatch($sformatf("token %0d %s: got %0h, expected %0h",
				tokens_checked, name, got, want));
	endtask

	// stimulus builders
	function automatic void push_text(input string s);
		foreach (s[i])
			queue_byte(s[i]);
	endfunction

	function automatic void gen_bytestring(input int len);
		push_text($sformatf("%0d:", len));
		repeat (len)
			queue_byte(8'($urandom_range(255)));
	endfunction

	function automatic int short_len();
		return ($urandom_range(9) < 8) ? $urandom_range(6) : $urandom_range(40);
	endfunction

	function automatic void gen_int();
		logic [63:0] mag;
		case ($urandom_range(5))
			0: mag = 64'($urandom_range(9));
			1: mag = 64'($urandom_range(100000));
			2: mag = {$urandom, $urandom};
			3: mag = INT_MAX;
			4: mag = {$urandom, $urandom} >> $urandom_range(63);
			default: mag = '0;
		endcase
		push_text("i");
		if ($urandom_range(1))
			push_text("-");
		if ($urandom_range(7) == 0)
			push_text("0");
		push_text($sformatf("%0d", mag));
		push_text("e");
	endfunction

	// one well-formed value with random content
	function automatic void gen_value(input int depth);
		int pick;
		pick = (depth >= 4) ? $urandom_range(5) : $urandom_range(9);
		if (pick <= 2) begin
			gen_int();
		end else if (pick <= 5) begin
			gen_bytestring(short_len());
		end else if (pick <= 7) begin
			push_text("l");
			repeat ($urandom_range(3))
				gen_value(depth + 1);
			push_text("e");
		end else begin
			push_text("d");
			repeat ($urandom_range(3)) begin
				gen_bytestring($urandom_range(1, 6));
				gen_value(depth + 1);
			end
			push_text("e");
		end
	endfunction

	// noise and broken sequences
	function automatic void gen_broken();
		int n;
		case ($urandom_range(9))
			0: repeat ($urandom_range(1, 4)) queue_byte(8'($urandom_range(255)));
			1: begin
				push_text("i");
				queue_byte(8'($urandom_range(255)));
				push_text("e");
			end
			2: case ($urandom_range(3))
				0: push_text("ie");
				1: push_text("i-e");
				2: push_text("i--1e");
				default: push_text("i1-e");
			endcase
			3: if ($urandom_range(1))
				push_text("i18446744073709551616e");
			else
				push_text($sformatf("i%0d%0d%0de", {$urandom, $urandom},
					$urandom_range(9), $urandom_range(9)));
			4: push_text($urandom_range(1) ? "4294967296:" : "99999999999:");
			5: push_text($sformatf("%0dx", $urandom_range(99)));
			6: push_text("e");
			7: begin
				n = $urandom_range(14, 18);
				repeat (n)
					push_text($urandom_range(1) ? "l" : "d");
				repeat (n + $urandom_range(1))
					push_text("e");
			end
			8: push_text($urandom_range(1) ? "i18446744073709551615e" : "i-9223372036854775808e");
			default: queue_byte($urandom_range(1) ? 8'h00 : 8'hFF);
		endcase
	endfunction

	// drive inputs at the falling edge; hold a byte until its transfer
	always @(negedge clk) begin
		if (!arst_n) begin
			byte_ch.valid  <= 1'b0;
			token_ch.ready <= 1'b0;
		end else begin
			if (!byte_ch.valid || byte_taken) begin
				if (byte_backlog.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
					byte_ch.valid     <= 1'b1;
					byte_ch.data_byte <= byte_backlog.pop_front();
				end else begin
					byte_ch.valid <= 1'b0;
				end
			end
			byte_taken = 1'b0;
			token_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// sample transfers at the rising edge: predict on input, check on output
	always @(posedge clk) begin
		bencode_token_t want;
		if (arst_n) begin
			if (byte_ch.valid && byte_ch.ready) begin
				tokenize_byte(byte_ch.data_byte);
				bytes_accepted++;
				byte_taken = 1'b1;
			end
			if (token_ch.valid && token_ch.ready) begin
				if (pending_tokens.size() == 0) begin
					log_mismatch($sformatf("unexpected token, kind %0d", token_ch.token_kind));
				end else begin
					want = pending_tokens.pop_front();
					compare_field("token_kind", 64'(token_ch.token_kind), 64'(want.kind));
					compare_field("int_value", token_ch.int_value, want.ival);
					compare_field("container_id", 64'(token_ch.container_id), 64'(want.cid));
					compare_field("string_data", 64'(token_ch.string_data), 64'(want.sdata));
					compare_field("first_of_string", 64'(token_ch.first_of_string),
						64'(want.first));
					compare_field("last_of_string", 64'(token_ch.last_of_string),
						64'(want.last));
					compare_field("error_code", 64'(token_ch.error_code), 64'(want.err));
				end
				tokens_checked++;
			end
		end
	end

	// stimulus, reset and end of run
	initial begin
		arst_n             = 1'b0;
		byte_ch.valid      = 1'b0;
		byte_ch.data_byte  = 8'h00;
		token_ch.ready     = 1'b0;
		byte_taken         = 1'b0;

		// directed: empty-stack end, extreme bytes, empty and short strings,
		// integers without digits, a negative integer, nesting, bad length and integer bytes
		push_text("e");
		queue_byte(8'h00);
		queue_byte(8'hFF);
		push_text("0:");
		push_text("2:");
		queue_byte(8'h00);
		queue_byte(8'hFF);
		push_text("ie");
		push_text("i-e");
		push_text("i-3e");
		push_text("ldee");
		push_text("1x");
		push_text("i5-");

		// random: mostly well-formed values, the rest broken
		while (byte_backlog.size() < 1650) begin
			if ($urandom_range(99) < 80)
				gen_value(0);
			else
				gen_broken();
		end

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (byte_backlog.size() != 0 || byte_ch.valid || pending_tokens.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
		if (pending_tokens.size() != 0)
			log_mismatch($sformatf("%0d tokens never arrived", pending_tokens.size()));

		$display("covered %0d bytes, %0d tokens: %0d integers, %0d string bytes, %0d empty strings",
			bytes_accepted, tokens_checked, kind_tally[KIND_INT], kind_tally[KIND_SBYTE],
			kind_tally[KIND_EMPTY]);
		$display("errors: empty stack %0d, stack full %0d, bad digit %0d, overflow %0d, too long %0d",
			err_tally[ERR_EMPTY_STACK], err_tally[ERR_STACK_FULL], err_tally[ERR_BAD_DIGIT],
			err_tally[ERR_INT_OVF], err_tally[ERR_TOO_LONG]);
		if (mismatch_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	// hard stop
	initial begin
		#1000000;
		$display("timeout with %0d tokens outstanding", pending_tokens.size());
		$display("end of test: mismatches");
		$finish;
	end

endmodule

`default_nettype wire
